/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/stunbr_pkg.sv */
// ----------------------------------------------------------------------------
// stunbr_pkg
// constants, types and the response byte table of the stun binding responder
// ----------------------------------------------------------------------------
`default_nettype none

package stunbr_pkg;

    localparam int          TXN_BYTES = 12;
    localparam int          TXN_IDX_W = 4;
    localparam int          HDR_LEN   = 20;
    localparam int          TXN_OFS   = 8;
    localparam logic [31:0] MAGIC     = 32'h2112_A442;
    localparam logic [15:0] TYPE_REQ  = 16'h0001;
    localparam logic [15:0] TYPE_RESP = 16'h0101;
    localparam logic [4:0]  RESP_LAST = 5'd31;

    localparam logic        KIND_BYTE = 1'b0;
    localparam logic        KIND_CONN = 1'b1;

    // configuration register indexes
    localparam logic [1:0]  REG_AWAIT    = 2'd0;
    localparam logic [1:0]  REG_TXN_HIGH = 2'd1;
    localparam logic [1:0]  REG_TXN_MID  = 2'd2;
    localparam logic [1:0]  REG_TXN_LOW  = 2'd3;

    // packet verdict from the parser on the accepted word
    typedef struct packed {
        logic req_hit;
        logic resp_hit;
        logic connected;
    } pkt_evt_t;

    // byte k of the binding success response
    function automatic logic [7:0] resp_byte_at(input logic [4:0] k,
                                                input logic [7:0] txn_byte,
                                                input logic [15:0] xport,
                                                input logic [31:0] xip);
        logic [7:0] b;
        b = 8'h00;
        case (k) inside
            5'd0, 5'd1:    b = 8'h01;
            5'd3:          b = 8'h0C;
            5'd4:          b = MAGIC[31:24];
            5'd5:          b = MAGIC[23:16];
            5'd6:          b = MAGIC[15:8];
            5'd7:          b = MAGIC[7:0];
            [5'd8:5'd19]:  b = txn_byte;
            5'd21:         b = 8'h20;
            5'd23:         b = 8'h08;
            5'd25:         b = 8'h01;
            5'd26:         b = xport[15:8];
            5'd27:         b = xport[7:0];
            5'd28:         b = xip[31:24];
            5'd29:         b = xip[23:16];
            5'd30:         b = xip[15:8];
            5'd31:         b = xip[7:0];
            default:       b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* hdl/stun_binding_responder.sv */
// ----------------------------------------------------------------------------
// stun_binding_responder
// answers stun binding requests and flags a matching binding response
// ----------------------------------------------------------------------------
// s_* takes the udp payload one byte per word with the source address and
// port; s_tlast marks the final byte. cfg_* writes awaiting_response and the
// expected transaction id (index 0..3); writes are taken in any cycle.
// m_* gives results: m_tuser low is a response byte (32 words, m_tlast on the
// last), m_tuser high a connected event (single word with m_tlast).
// Payload bytes are taken one per cycle while no burst runs. A binding
// request starts a 32-word burst: its last byte sets the busy flag, then
// the output register loads each byte; s_tready stays low until the 32nd
// byte is loaded, since the burst reads the stored id. A connected event
// goes to the pending register, then the output register, and does not
// hold the input. A stalled receiver holds m_tdata and the burst counter.
// Reset clears the header state, configuration and output valid; the stored
// id is not cleared as it is only read after a full header rewrites it.
// ----------------------------------------------------------------------------
`default_nettype none

module stun_binding_responder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // data_byte[7:0], src_ip[39:8], src_port[55:40]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // resp_byte[7:0], peer_ip[39:8], peer_port[55:40]
    output logic             m_tuser,   // kind[0]
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import stunbr_pkg::*;

    `include "assert_macros.svh"

    logic                in_accept;
    pkt_evt_t            evt;
    logic [7:0]          txn_byte;
    logic [3:0]          rd_idx;
    logic                slot_free;
    logic                load_evt;
    logic                load_gen;

    logic                busy_reg, busy_next;
    logic [4:0]          idx_reg, idx_next;
    logic [31:0]         gen_ip_reg;
    logic [15:0]         gen_port_reg;
    logic                pend_reg, pend_next;
    logic [31:0]         pend_ip_reg;
    logic [15:0]         pend_port_reg;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_byte_reg;
    logic                out_kind_reg;
    logic                out_last_reg;
    logic [31:0]         out_ip_reg;
    logic [15:0]         out_port_reg;

    assign s_tready  = !busy_reg;
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign rd_idx = 4'(idx_reg - 5'(TXN_OFS));

    stunbr_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_accept  (in_accept),
        .data_byte  (s_tdata[7:0]),
        .last_byte  (s_tlast),
        .cfg_accept (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .rd_idx     (rd_idx),
        .rd_byte    (txn_byte),
        .evt        (evt)
    );

    // a pending event goes out before any burst that follows it
    assign slot_free = !out_valid_reg || m_tready;
    assign load_evt  = slot_free && pend_reg;
    assign load_gen  = slot_free && !pend_reg && busy_reg;

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        if (load_evt || load_gen)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        if (load_evt)
            pend_next = 1'b0;
        if (evt.resp_hit)
            pend_next = 1'b1;
        if (load_gen)
        begin
            idx_next = idx_reg + 5'd1;
            if (idx_reg == RESP_LAST)
                busy_next = 1'b0;
        end
        if (evt.req_hit)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.req_hit)
        begin
            gen_ip_reg   <= s_tdata[39:8];
            gen_port_reg <= s_tdata[55:40];
        end
        if (evt.resp_hit)
        begin
            pend_ip_reg   <= s_tdata[39:8];
            pend_port_reg <= s_tdata[55:40];
        end
        if (load_evt)
        begin
            out_kind_reg <= KIND_CONN;
            out_byte_reg <= 8'h00;
            out_last_reg <= 1'b1;
            out_ip_reg   <= pend_ip_reg;
            out_port_reg <= pend_port_reg;
        end
        else if (load_gen)
        begin
            out_kind_reg <= KIND_BYTE;
            out_byte_reg <= resp_byte_at(idx_reg, txn_byte, gen_port_reg ^ MAGIC[31:16],
                                         gen_ip_reg ^ MAGIC);
            out_last_reg <= (idx_reg == RESP_LAST);
            out_ip_reg   <= gen_ip_reg;
            out_port_reg <= gen_port_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_port_reg, out_ip_reg, out_byte_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // connected event is a single word carrying no response byte
    `ASSERT_SAME(a_evt_single, clk, rst_n, m_tvalid && m_tuser, m_tlast && m_tdata[7:0] == 8'h00)
    // loading the final response byte ends the burst
    `ASSERT_NEXT(a_burst_end, clk, rst_n, load_gen && idx_reg == RESP_LAST && !evt.req_hit,
                 !busy_reg)
    // the connected flag only rises after the last byte of an accepted packet
    `ASSERT_SAME(a_conn_cause, clk, rst_n, $rose(evt.connected),
                 $past(in_accept && s_tlast))

endmodule

`default_nettype wire

/* hdl/stunbr_parse.sv */
// ----------------------------------------------------------------------------
// stunbr_parse
// header capture, transaction id store, configuration registers and verdict
// ----------------------------------------------------------------------------
`default_nettype none

module stunbr_parse (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_accept,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  last_byte,
    input  wire logic                  cfg_accept,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [31:0]           cfg_data,
    input  wire logic [3:0]            rd_idx,
    output logic [7:0]                 rd_byte,
    output stunbr_pkg::pkt_evt_t       evt
);
    import stunbr_pkg::*;

    logic        awaiting_reg;
    logic [31:0] txn_high_reg;
    logic [31:0] txn_mid_reg;
    logic [31:0] txn_low_reg;
    logic        connected_reg;
    logic [4:0]  count_reg;
    logic [15:0] type_reg;
    logic [31:0] cookie_reg;
    logic        match_reg;
    logic [7:0]  txn_store [TXN_BYTES];

    logic [4:0]  count_next;
    logic [15:0] type_next;
    logic [31:0] cookie_next;
    logic        match_next;
    logic        store_we;
    logic [3:0]  store_idx;
    logic [31:0] exp_word;
    logic [7:0]  exp_byte;
    logic        hdr_ok;

    assign store_idx = 4'(count_reg - 5'(TXN_OFS));

    always_comb
    begin
        count_next  = count_reg;
        type_next   = type_reg;
        cookie_next = cookie_reg;
        match_next  = match_reg;
        store_we    = 1'b0;
        if (count_reg < 5'(HDR_LEN))
        begin
            count_next = count_reg + 5'd1;
            if (count_reg < 5'd2)
                type_next = {type_reg[7:0], data_byte};
            else if (count_reg >= 5'd4 && count_reg < 5'(TXN_OFS))
                cookie_next = {cookie_reg[23:0], data_byte};
            else if (count_reg >= 5'(TXN_OFS))
            begin
                store_we = 1'b1;
                if (data_byte != exp_byte)
                    match_next = 1'b0;
            end
        end
    end

    // expected id byte for the current position, big endian within each word
    always_comb
    begin
        if (store_idx < 4'd4)
            exp_word = txn_high_reg;
        else if (store_idx < 4'd8)
            exp_word = txn_mid_reg;
        else
            exp_word = txn_low_reg;
        case (store_idx[1:0])
            2'd0:    exp_byte = exp_word[31:24];
            2'd1:    exp_byte = exp_word[23:16];
            2'd2:    exp_byte = exp_word[15:8];
            default: exp_byte = exp_word[7:0];
        endcase
    end

    assign hdr_ok = last_byte && (count_next >= 5'(HDR_LEN)) && (cookie_next == MAGIC);

    always_comb
    begin
        evt.req_hit   = in_accept && hdr_ok && (type_next == TYPE_REQ);
        evt.resp_hit  = in_accept && hdr_ok && (type_next == TYPE_RESP) && awaiting_reg
                        && !connected_reg && match_next;
        evt.connected = connected_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg  <= 1'b0;
            txn_high_reg  <= '0;
            txn_mid_reg   <= '0;
            txn_low_reg   <= '0;
            connected_reg <= 1'b0;
            count_reg     <= '0;
            type_reg      <= '0;
            cookie_reg    <= '0;
            match_reg     <= 1'b1;
        end
        else
        begin
            if (cfg_accept)
            begin
                unique case (cfg_index)
                    REG_AWAIT:
                    begin
                        awaiting_reg <= cfg_data[0];
                        if (cfg_data[0])
                            connected_reg <= 1'b0;
                    end
                    REG_TXN_HIGH: txn_high_reg <= cfg_data;
                    REG_TXN_MID:  txn_mid_reg  <= cfg_data;
                    REG_TXN_LOW:  txn_low_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (evt.resp_hit)
                connected_reg <= 1'b1;
            if (in_accept)
            begin
                if (last_byte)
                begin
                    count_reg  <= '0;
                    type_reg   <= '0;
                    cookie_reg <= '0;
                    match_reg  <= 1'b1;
                end
                else
                begin
                    count_reg  <= count_next;
                    type_reg   <= type_next;
                    cookie_reg <= cookie_next;
                    match_reg  <= match_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && store_we)
            txn_store[store_idx] <= data_byte;
    end

    assign rd_byte = (rd_idx < 4'(TXN_BYTES)) ? txn_store[rd_idx] : 8'h00;

endmodule

`default_nettype wire
